[hdl/tmgr_pkg.sv]
// Package for the text-mode glyph renderer: geometry constants, field widths
// and the glyph store write port type. No dependencies.
`default_nettype none

package tmgr_pkg;

    // Cell geometry and screen size
    localparam int GLYPH_HEIGHT = 16;
    localparam int GLYPH_WIDTH  = 8;
    localparam int COLUMNS      = 80;
    localparam int ROWS         = 25;

    // Glyph store
    localparam int STORE_DEPTH = 4096;
    localparam int STORE_AW    = 12;
    localparam int BYTE_W      = 8;

    // Field widths
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int COL_W    = 7;
    localparam int ROW_W    = 5;
    localparam int PLINE_W  = 4;
    localparam int COLOR_W  = 4;
    localparam int PIXELS_W = GLYPH_WIDTH * COLOR_W;

    // Line counters: one that indexes a row, one that can hold the height
    localparam int LINE_W  = $clog2(GLYPH_HEIGHT);
    localparam int LINE_CW = $clog2(GLYPH_HEIGHT + 1);

    // Stream payload sizes
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 48;

    // Operation codes (tuser bit 0 on the input side)
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    // Background bit that doubles as the blink flag
    localparam int BLINK_BIT = 3;

    typedef struct packed {
        logic                en;
        logic [STORE_AW-1:0] addr;
        logic [BYTE_W-1:0]   data;
    } glyph_wr_t;

endpackage

`default_nettype wire

[hdl/tmgr_glyph_ram.sv]
// Glyph store: single write port, single registered read port with enable.
// Depends on tmgr_pkg. Contents are undefined after reset.
`default_nettype none

module tmgr_glyph_ram
    import tmgr_pkg::*;
(
    input  wire logic                clk,
    input  wire glyph_wr_t           wr,
    input  wire logic                rd_en,
    input  wire logic [STORE_AW-1:0] rd_addr,
    output logic      [BYTE_W-1:0]   rd_data
);

    logic [BYTE_W-1:0] mem [STORE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        // read data holds while not enabled
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[hdl/text_mode_glyph_renderer.sv]
// Text-mode glyph renderer top level: stream ports, row sequencer, color
// expansion and output register. Depends on tmgr_pkg and tmgr_glyph_ram.
// Load item: written to the glyph store in the accept cycle; input ready stays high.
// Render item: rows pass the glyph store read register, then the output register,
// one row per cycle (GLYPH_HEIGHT rows) while m_axis_tready holds, limited by the single
// glyph store read port; input ready again as the last row enters the output register.
// Reset (rst_n low, async) clears the sequencer and output valid; the glyph
// store is not cleared and must be loaded before use.
`default_nettype none

module text_mode_glyph_renderer
    import tmgr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // font_index[11:0], font_byte[19:12], char_code[27:20], attribute[35:28],
    // blink_phase[36], cell_column[43:37], cell_row[48:44], zero fill[55:49]
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
    // opcode[0]
    input  wire logic                  s_axis_tuser,

    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // out_column[6:0], out_row[11:7], pixel_line[15:12], pixels[47:16]
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    output logic                       m_axis_tlast
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    // Input field unpacking
    logic [STORE_AW-1:0] in_font_index;
    logic [BYTE_W-1:0]   in_font_byte;
    logic [CHAR_W-1:0]   in_char_code;
    logic [ATTR_W-1:0]   in_attribute;
    logic                in_blink_phase;
    logic [COL_W-1:0]    in_cell_column;
    logic [ROW_W-1:0]    in_cell_row;

    assign in_font_index  = s_axis_tdata[11:0];
    assign in_font_byte   = s_axis_tdata[19:12];
    assign in_char_code   = s_axis_tdata[27:20];
    assign in_attribute   = s_axis_tdata[35:28];
    assign in_blink_phase = s_axis_tdata[36];
    assign in_cell_column = s_axis_tdata[43:37];
    assign in_cell_row    = s_axis_tdata[48:44];

    state_t              state_reg, state_next;
    logic [STORE_AW-1:0] base_reg, base_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [COLOR_W-1:0]  fg_reg, fg_next;
    logic [COLOR_W-1:0]  bg_reg, bg_next;
    logic [LINE_CW-1:0]  rd_line_reg, rd_line_next;   // next row to fetch
    logic [LINE_W-1:0]   dv_line_reg, dv_line_next;   // row held at RAM output
    logic                dv_reg, dv_next;             // RAM output holds a row

    logic                      out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0]     out_data_reg, out_data_next;
    logic                      out_last_reg, out_last_next;

    glyph_wr_t           ram_wr;
    logic                ram_rd_en;
    logic [STORE_AW-1:0] ram_rd_addr;
    logic [BYTE_W-1:0]   ram_rd_data;

    logic                accept;
    logic                out_free;
    logic                consume;
    logic [COLOR_W-1:0]  attr_fg;
    logic [COLOR_W-1:0]  attr_bg;
    logic [PIXELS_W-1:0] row_pixels;
    logic                line_is_last;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign consume       = (state_reg == ST_RUN) && dv_reg && out_free;
    assign line_is_last  = (dv_line_reg == LINE_W'(GLYPH_HEIGHT - 1));

    // Attribute decode; a blinking cell drops background bit 3 and hides
    // its foreground in the even phase.
    always_comb
    begin
        attr_fg = in_attribute[3:0];
        attr_bg = in_attribute[7:4];
        if (attr_bg[BLINK_BIT])
        begin
            attr_bg[BLINK_BIT] = 1'b0;
            if (!in_blink_phase)
            begin
                attr_fg = attr_bg;
            end
        end
    end

    // Row expansion, leftmost pixel in the low nibble
    always_comb
    begin
        for (int b = 0; b < GLYPH_WIDTH; b++)
        begin
            row_pixels[b*COLOR_W +: COLOR_W] = ram_rd_data[b] ? fg_reg : bg_reg;
        end
    end

    assign ram_wr.en   = accept && (s_axis_tuser == OP_LOAD);
    assign ram_wr.addr = in_font_index;
    assign ram_wr.data = in_font_byte;

    assign ram_rd_addr = base_reg + STORE_AW'(rd_line_reg);

    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        fg_next        = fg_reg;
        bg_next        = bg_reg;
        rd_line_next   = rd_line_reg;
        dv_line_next   = dv_line_reg;
        dv_next        = dv_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        ram_rd_en      = 1'b0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (s_axis_tuser == OP_RENDER))
                begin
                    state_next   = ST_RUN;
                    base_next    = STORE_AW'(32'(in_char_code) * GLYPH_HEIGHT);
                    col_next     = ({1'b0, in_cell_column} >= 8'(COLUMNS))
                                   ? COL_W'(COLUMNS - 1) : in_cell_column;
                    row_next     = ({2'b00, in_cell_row} >= 7'(ROWS))
                                   ? ROW_W'(ROWS - 1) : in_cell_row;
                    fg_next      = attr_fg;
                    bg_next      = attr_bg;
                    rd_line_next = '0;
                    dv_line_next = '0;
                    dv_next      = 1'b0;
                end
            end
            ST_RUN:
            begin
                if (consume)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {row_pixels, PLINE_W'(dv_line_reg), row_reg, col_reg};
                    out_last_next  = line_is_last;
                    dv_line_next   = dv_line_reg + LINE_W'(1);
                end
                // fetch the next row when the RAM output is free or being taken
                if ((rd_line_reg != LINE_CW'(GLYPH_HEIGHT)) && (!dv_reg || consume))
                begin
                    ram_rd_en    = 1'b1;
                    rd_line_next = rd_line_reg + LINE_CW'(1);
                    dv_next      = 1'b1;
                end
                else if (consume)
                begin
                    dv_next = 1'b0;
                end
                if ((rd_line_reg == LINE_CW'(GLYPH_HEIGHT)) && consume)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            rd_line_reg   <= '0;
            dv_line_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            dv_reg        <= dv_next;
            out_valid_reg <= out_valid_next;
            rd_line_reg   <= rd_line_next;
            dv_line_reg   <= dv_line_next;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        base_reg     <= base_next;
        col_reg      <= col_next;
        row_reg      <= row_next;
        fg_reg       <= fg_next;
        bg_reg       <= bg_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    tmgr_glyph_ram u_glyph_ram (
        .clk     (clk),
        .wr      (ram_wr),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire
